// ----- rtl/bdcl_pkg.sv -----
// ----------------------------------------------------------------------------
// Button debounce and command latch package
// Shared constants, codes and keyword tables for the button debounce and
// command latch block.
// ----------------------------------------------------------------------------
package bdcl_pkg;

   localparam int LINE_MAX   = 64;
   localparam int LINE_LEN_W = $clog2(LINE_MAX);
   localparam int TICKS_W    = 16;
   localparam int NUM_KW     = 4;
   localparam int KW_CHARS   = 8;
   localparam int TOK_LEN_W  = 4;
   localparam int NUM_FLAGS  = 4;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_BYTE = 2'd1;
   localparam logic [1:0] OP_TAKE = 2'd2;

   typedef enum logic [2:0] {
      REPLY_STATUS  = 3'd0,
      REPLY_NIGHT   = 3'd1,
      REPLY_REQUEST = 3'd2,
      REPLY_HELP    = 3'd3,
      REPLY_UNKNOWN = 3'd4,
      REPLY_TAKEN   = 3'd5
   } reply_type;

   localparam int FLAG_REQUEST = 0;
   localparam int FLAG_NIGHT   = 1;
   localparam int FLAG_REPORT  = 2;
   localparam int FLAG_CHANGED = 3;

   localparam logic [NUM_FLAGS-1:0] MASK_REQUEST = 4'b1001;
   localparam logic [NUM_FLAGS-1:0] MASK_NIGHT   = 4'b1010;
   localparam logic [NUM_FLAGS-1:0] MASK_STATUS  = 4'b1100;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   localparam logic [7:0] KW_TEXT [NUM_KW][KW_CHARS] = '{
      '{8'h53, 8'h54, 8'h41, 8'h54, 8'h55, 8'h53, 8'h00, 8'h00},
      '{8'h4E, 8'h49, 8'h47, 8'h48, 8'h54, 8'h00, 8'h00, 8'h00},
      '{8'h52, 8'h45, 8'h51, 8'h55, 8'h45, 8'h53, 8'h54, 8'h00},
      '{8'h48, 8'h45, 8'h4C, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [TOK_LEN_W-1:0] KW_LEN [NUM_KW] = '{4'd6, 4'd5, 4'd7, 4'd4};

endpackage

// ----- rtl/bdcl_if.sv -----
// ----------------------------------------------------------------------------
// Button debounce and command latch channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------
interface bdcl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic       ns_button_low;
   logic       mode_button_low;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output ns_button_low,
                   output mode_button_low, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input ns_button_low,
                   input mode_button_low, input rx_byte, output ready);
endinterface

interface bdcl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] reply;
   logic       call_flag;
   logic       night_flag;
   logic       report_flag;
   logic       changed;

   modport source (output valid, output reply, output call_flag, output night_flag,
                   output report_flag, output changed, input ready);
   modport sink   (input valid, input reply, input call_flag, input night_flag,
                   input report_flag, input changed, output ready);
endinterface

// ----- rtl/bdcl_debounce.sv -----
// ----------------------------------------------------------------------------
// Button debouncer
// Tracks the stable level of one active-low button and flags a newly
// accepted high level on the tick that accepts it.
// ----------------------------------------------------------------------------
module bdcl_debounce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick,
   input  logic                        level,
   input  logic [bdcl_pkg::TICKS_W-1:0] ticks,
   output logic                        pressed
);

   logic                         stable_ff, stable_in;
   logic [bdcl_pkg::TICKS_W-1:0] count_ff, count_in;
   logic [bdcl_pkg::TICKS_W-1:0] count_inc;

   assign count_inc = (&count_ff) ? count_ff : count_ff + 1'b1;

   always_comb begin
      stable_in = stable_ff;
      count_in  = count_ff;
      pressed   = 1'b0;
      if (tick) begin
         if (level == stable_ff) begin
            count_in = '0;
         end else if (count_inc >= ticks) begin
            stable_in = level;
            count_in  = '0;
            pressed   = level;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/button_debounce_command_latch.sv -----
// ----------------------------------------------------------------------------
// Button debounce and command latch
// Debounces two buttons, parses serial command lines and keeps the pending
// command flags that a consumer collects with a take request.
// ----------------------------------------------------------------------------
// The block accepts one request in every clock cycle. A request is captured
// in an input register and processed in a cycle in which the result register
// is empty or its result is being taken, and its result, if any, is loaded
// into the result register at the end of that cycle, from where it can
// be taken at the next clock edge. The result register lets a new request be
// taken while an earlier result waits; the block stalls whenever that register
// is full and its result is not being taken in the same cycle. Ticks, serial
// bytes that do not end a line, empty lines, lines without a token and the
// unused opcode produce no result.
module button_debounce_command_latch (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [bdcl_pkg::TICKS_W-1:0]     csr_write_data,
   bdcl_req_if.sink                         req_chan,
   bdcl_rsp_if.source                       rsp_chan
);

   typedef enum logic [1:0] {
      PHASE_SKIP  = 2'd0,
      PHASE_TOKEN = 2'd1,
      PHASE_ENDED = 2'd2,
      PHASE_EMPTY = 2'd3
   } phase_type;

   logic [bdcl_pkg::TICKS_W-1:0] ticks_ff;

   logic       in_v_ff, in_v_in;
   logic [1:0] op_ff;
   logic       ns_pin_ff;
   logic       mode_pin_ff;
   logic [7:0] byte_ff;

   logic [bdcl_pkg::NUM_FLAGS-1:0]  flags_ff, flags_in;
   logic [bdcl_pkg::LINE_LEN_W-1:0] line_len_ff, line_len_in;
   phase_type                       phase_ff, phase_in;
   logic [bdcl_pkg::TOK_LEN_W-1:0]  tok_len_ff, tok_len_in;
   logic [bdcl_pkg::NUM_KW-1:0]     match_ff, match_in;

   logic                            rsp_v_ff, rsp_v_in;
   bdcl_pkg::reply_type             reply_ff, reply_in;
   logic [bdcl_pkg::NUM_FLAGS-1:0]  out_flags_ff, out_flags_in;

   logic proc;
   logic load_result;
   logic is_tick;
   logic ns_press;
   logic mode_press;
   logic is_space;
   logic [7:0] upper;

   assign proc    = in_v_ff && (!rsp_v_ff || rsp_chan.ready);
   assign is_tick = proc && (op_ff == bdcl_pkg::OP_TICK);
   assign req_chan.ready = !in_v_ff || proc;

   assign is_space = (byte_ff == bdcl_pkg::CHAR_SPACE) || (byte_ff == bdcl_pkg::CHAR_TAB) ||
                     (byte_ff == bdcl_pkg::CHAR_VT) || (byte_ff == bdcl_pkg::CHAR_FF);
   assign upper = (byte_ff >= bdcl_pkg::CHAR_LOW_A && byte_ff <= bdcl_pkg::CHAR_LOW_Z) ?
                  byte_ff - bdcl_pkg::CASE_SHIFT : byte_ff;

   bdcl_debounce u_ns_debounce (
      .clock   (clock),
      .reset   (reset),
      .tick    (is_tick),
      .level   (ns_pin_ff),
      .ticks   (ticks_ff),
      .pressed (ns_press)
   );

   bdcl_debounce u_mode_debounce (
      .clock   (clock),
      .reset   (reset),
      .tick    (is_tick),
      .level   (mode_pin_ff),
      .ticks   (ticks_ff),
      .pressed (mode_press)
   );

   always_comb begin
      flags_in     = flags_ff;
      line_len_in  = line_len_ff;
      phase_in     = phase_ff;
      tok_len_in   = tok_len_ff;
      match_in     = match_ff;
      load_result  = 1'b0;
      reply_in     = bdcl_pkg::REPLY_UNKNOWN;
      out_flags_in = '0;
      if (proc) begin
         unique case (op_ff)
            bdcl_pkg::OP_TICK: begin
               if (ns_press) begin
                  flags_in = flags_in | bdcl_pkg::MASK_REQUEST;
               end
               if (mode_press) begin
                  flags_in = flags_in | bdcl_pkg::MASK_NIGHT;
               end
            end
            bdcl_pkg::OP_BYTE: begin
               if (byte_ff == bdcl_pkg::CHAR_CR || byte_ff == bdcl_pkg::CHAR_LF) begin
                  if (line_len_ff != '0) begin
                     if ((phase_ff == PHASE_TOKEN || phase_ff == PHASE_ENDED) &&
                         tok_len_ff != '0) begin
                        load_result = 1'b1;
                        for (int k = 0; k < bdcl_pkg::NUM_KW; k++) begin
                           if (match_ff[k] && tok_len_ff == bdcl_pkg::KW_LEN[k]) begin
                              reply_in = bdcl_pkg::reply_type'(3'(k));
                           end
                        end
                        case (reply_in)
                           bdcl_pkg::REPLY_STATUS:  flags_in = flags_ff | bdcl_pkg::MASK_STATUS;
                           bdcl_pkg::REPLY_NIGHT:   flags_in = flags_ff | bdcl_pkg::MASK_NIGHT;
                           bdcl_pkg::REPLY_REQUEST: flags_in = flags_ff | bdcl_pkg::MASK_REQUEST;
                           default: ;
                        endcase
                     end
                     line_len_in = '0;
                     phase_in    = PHASE_SKIP;
                     tok_len_in  = '0;
                     match_in    = '1;
                  end
               end else if (line_len_ff <
                            bdcl_pkg::LINE_LEN_W'(bdcl_pkg::LINE_MAX - 1)) begin
                  line_len_in = line_len_ff + 1'b1;
                  if (phase_ff == PHASE_SKIP || phase_ff == PHASE_TOKEN) begin
                     if (byte_ff == bdcl_pkg::CHAR_NUL) begin
                        phase_in = (phase_ff == PHASE_TOKEN) ? PHASE_ENDED : PHASE_EMPTY;
                     end else if (is_space) begin
                        if (phase_ff == PHASE_TOKEN) begin
                           phase_in = PHASE_ENDED;
                        end
                     end else begin
                        phase_in = PHASE_TOKEN;
                        for (int k = 0; k < bdcl_pkg::NUM_KW; k++) begin
                           if (tok_len_ff >= bdcl_pkg::KW_LEN[k] ||
                               bdcl_pkg::KW_TEXT[k][tok_len_ff[2:0]] != upper) begin
                              match_in[k] = 1'b0;
                           end
                        end
                        if (tok_len_ff < bdcl_pkg::TOK_LEN_W'(bdcl_pkg::KW_CHARS)) begin
                           tok_len_in = tok_len_ff + 1'b1;
                        end
                     end
                  end
               end
            end
            bdcl_pkg::OP_TAKE: begin
               load_result  = 1'b1;
               reply_in     = bdcl_pkg::REPLY_TAKEN;
               out_flags_in = flags_ff;
               flags_in     = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      in_v_in = in_v_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_v_in = 1'b1;
      end else if (proc) begin
         in_v_in = 1'b0;
      end
      rsp_v_in = rsp_v_ff;
      if (load_result) begin
         rsp_v_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff    <= bdcl_pkg::TICKS_W'(5);
         in_v_ff     <= 1'b0;
         rsp_v_ff    <= 1'b0;
         flags_ff    <= '0;
         line_len_ff <= '0;
         phase_ff    <= PHASE_SKIP;
         tok_len_ff  <= '0;
         match_ff    <= '1;
      end else begin
         if (csr_write_enable) begin
            ticks_ff <= csr_write_data;
         end
         in_v_ff     <= in_v_in;
         rsp_v_ff    <= rsp_v_in;
         flags_ff    <= flags_in;
         line_len_ff <= line_len_in;
         phase_ff    <= phase_in;
         tok_len_ff  <= tok_len_in;
         match_ff    <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         op_ff       <= req_chan.opcode;
         ns_pin_ff   <= req_chan.ns_button_low;
         mode_pin_ff <= req_chan.mode_button_low;
         byte_ff     <= req_chan.rx_byte;
      end
      if (load_result) begin
         reply_ff     <= reply_in;
         out_flags_ff <= out_flags_in;
      end
   end

   assign rsp_chan.valid       = rsp_v_ff;
   assign rsp_chan.reply       = reply_ff;
   assign rsp_chan.call_flag   = out_flags_ff[bdcl_pkg::FLAG_REQUEST];
   assign rsp_chan.night_flag  = out_flags_ff[bdcl_pkg::FLAG_NIGHT];
   assign rsp_chan.report_flag = out_flags_ff[bdcl_pkg::FLAG_REPORT];
   assign rsp_chan.changed     = out_flags_ff[bdcl_pkg::FLAG_CHANGED];

endmodule

// ----- sim/latch_check_pkg.sv -----
// ----------------------------------------------------------------------------
// Command latch scoreboard
// Tracks the debounce, line parsing and flag state of the button debounce and
// command latch block and checks each result against the predicted replies.
// ----------------------------------------------------------------------------
package latch_check_pkg;

   typedef enum logic [1:0] {
      SKIP_BLANKS,
      IN_TOKEN,
      TOKEN_ENDED,
      TEXT_ENDED
   } token_phase_type;

   typedef struct {
      bdcl_pkg::reply_type            reply;
      logic [bdcl_pkg::NUM_FLAGS-1:0] flags;
   } latch_reply_type;

   class command_latch_scoreboard;
      latch_reply_type                expected_replies[$];
      int                             mismatches;
      logic [bdcl_pkg::TICKS_W-1:0]   debounce_ticks;
      logic                           ns_stable;
      logic                           mode_stable;
      logic [bdcl_pkg::TICKS_W-1:0]   ns_count;
      logic [bdcl_pkg::TICKS_W-1:0]   mode_count;
      logic [bdcl_pkg::NUM_FLAGS-1:0] pending;
      int                             line_length;
      int                             token_length;
      token_phase_type                phase;
      logic [bdcl_pkg::NUM_KW-1:0]    candidates;
      string                          keywords[bdcl_pkg::NUM_KW];

      function new();
         keywords       = '{"STATUS", "NIGHT", "REQUEST", "HELP"};
         mismatches     = 0;
         debounce_ticks = bdcl_pkg::TICKS_W'(5);
         ns_stable      = 1'b0;
         mode_stable    = 1'b0;
         ns_count       = '0;
         mode_count     = '0;
         pending        = '0;
         clear_line();
      endfunction

      function void set_debounce(logic [bdcl_pkg::TICKS_W-1:0] value);
         debounce_ticks = value;
      endfunction

      function int outstanding();
         return expected_replies.size();
      endfunction

      function void clear_line();
         line_length  = 0;
         token_length = 0;
         phase        = SKIP_BLANKS;
         candidates   = '1;
      endfunction

      function bit settle(logic level, inout logic stable,
                          inout logic [bdcl_pkg::TICKS_W-1:0] count);
         if (level == stable) begin
            count = '0;
            return 1'b0;
         end
         if (count != '1)
            count++;
         if (count >= debounce_ticks) begin
            stable = level;
            count  = '0;
            return level;
         end
         return 1'b0;
      endfunction

      function void feed_char(logic [7:0] c);
         logic [7:0] up;
         if (phase == TOKEN_ENDED || phase == TEXT_ENDED)
            return;
         if (c == bdcl_pkg::CHAR_NUL) begin
            phase = (phase == IN_TOKEN) ? TOKEN_ENDED : TEXT_ENDED;
            return;
         end
         if (c == bdcl_pkg::CHAR_SPACE || c == bdcl_pkg::CHAR_TAB ||
             c == bdcl_pkg::CHAR_VT || c == bdcl_pkg::CHAR_FF) begin
            if (phase == IN_TOKEN)
               phase = TOKEN_ENDED;
            return;
         end
         phase = IN_TOKEN;
         up = (c >= bdcl_pkg::CHAR_LOW_A && c <= bdcl_pkg::CHAR_LOW_Z) ?
              c - bdcl_pkg::CASE_SHIFT : c;
         for (int k = 0; k < bdcl_pkg::NUM_KW; k++) begin
            if (token_length >= keywords[k].len() || keywords[k][token_length] != up)
               candidates[k] = 1'b0;
         end
         if (token_length < bdcl_pkg::KW_CHARS)
            token_length++;
      endfunction

      function void end_line();
         latch_reply_type outcome;
         if (line_length == 0)
            return;
         if ((phase == IN_TOKEN || phase == TOKEN_ENDED) && token_length > 0) begin
            outcome.reply = bdcl_pkg::REPLY_UNKNOWN;
            outcome.flags = '0;
            for (int k = 0; k < bdcl_pkg::NUM_KW; k++) begin
               if (candidates[k] && token_length == keywords[k].len())
                  outcome.reply = bdcl_pkg::reply_type'(3'(k));
            end
            case (outcome.reply)
               bdcl_pkg::REPLY_STATUS: begin
                  pending |= bdcl_pkg::MASK_STATUS;
               end
               bdcl_pkg::REPLY_NIGHT: begin
                  pending |= bdcl_pkg::MASK_NIGHT;
               end
               bdcl_pkg::REPLY_REQUEST: begin
                  pending |= bdcl_pkg::MASK_REQUEST;
               end
               default: begin
               end
            endcase
            expected_replies.push_back(outcome);
         end
         clear_line();
      endfunction

      function void apply_request(logic [1:0] op, logic ns_pin, logic mode_pin,
                                  logic [7:0] rx);
         latch_reply_type taken;
         case (op)
            bdcl_pkg::OP_TICK: begin
               if (settle(ns_pin, ns_stable, ns_count))
                  pending |= bdcl_pkg::MASK_REQUEST;
               if (settle(mode_pin, mode_stable, mode_count))
                  pending |= bdcl_pkg::MASK_NIGHT;
            end
            bdcl_pkg::OP_BYTE: begin
               if (rx == bdcl_pkg::CHAR_CR || rx == bdcl_pkg::CHAR_LF) begin
                  end_line();
               end else if (line_length < bdcl_pkg::LINE_MAX - 1) begin
                  line_length++;
                  feed_char(rx);
               end
            end
            bdcl_pkg::OP_TAKE: begin
               taken.reply = bdcl_pkg::REPLY_TAKEN;
               taken.flags = pending;
               expected_replies.push_back(taken);
               pending = '0;
            end
            default: begin
            end
         endcase
      endfunction

      function void check_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(logic [2:0] reply, logic call_flag, logic night_flag,
                                   logic report_flag, logic changed);
         latch_reply_type want;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual reply %0d",
                     $time, reply);
            mismatches++;
            return;
         end
         want = expected_replies.pop_front();
         check_field("reply", 8'(want.reply), 8'(reply));
         check_field("call_flag", 8'(want.flags[bdcl_pkg::FLAG_REQUEST]), 8'(call_flag));
         check_field("night_flag", 8'(want.flags[bdcl_pkg::FLAG_NIGHT]), 8'(night_flag));
         check_field("report_flag", 8'(want.flags[bdcl_pkg::FLAG_REPORT]), 8'(report_flag));
         check_field("changed", 8'(want.flags[bdcl_pkg::FLAG_CHANGED]), 8'(changed));
      endfunction
   endclass

endpackage

// ----- sim/button_debounce_command_latch_tb.sv -----
// ----------------------------------------------------------------------------
// Button debounce and command latch testbench
// Drives ticks, serial command lines and take requests with random idling on
// both channels, walks the debounce setting through several values including
// both extremes, and checks every result against a scoreboard prediction.
// ----------------------------------------------------------------------------
module button_debounce_command_latch_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [bdcl_pkg::TICKS_W-1:0] csr_write_data;

   bit         steady_phase = 1'b0;
   int         sent_items = 0;
   int         current_debounce = 5;
   int         phase_ticks[5] = '{0, 1, 3, 8, 2};
   logic [7:0] line_buf[$];
   string      command_words[bdcl_pkg::NUM_KW] = '{"STATUS", "NIGHT", "REQUEST", "HELP"};

   latch_check_pkg::command_latch_scoreboard latch_board;

   bdcl_req_if req_chan();
   bdcl_rsp_if rsp_chan();

   button_debounce_command_latch DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = steady_phase || ($urandom_range(99) >= 25);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            latch_board.check_response(rsp_chan.reply, rsp_chan.call_flag,
                                       rsp_chan.night_flag, rsp_chan.report_flag,
                                       rsp_chan.changed);
      end
   end

   task automatic send_request(input logic [1:0] op, input logic ns_pin,
                               input logic mode_pin, input logic [7:0] rx);
      int gap;
      gap = 0;
      if (!steady_phase)
         while ($urandom_range(99) < 25)
            gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid           = 1'b1;
      req_chan.opcode          = op;
      req_chan.ns_button_low   = ns_pin;
      req_chan.mode_button_low = mode_pin;
      req_chan.rx_byte         = rx;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      latch_board.apply_request(op, ns_pin, mode_pin, rx);
      if (op != OP_UNUSED)
         sent_items++;
   endtask

   task automatic send_take();
      send_request(bdcl_pkg::OP_TAKE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   8'($urandom_range(255)));
   endtask

   task automatic send_tick(input logic ns_pin, input logic mode_pin);
      send_request(bdcl_pkg::OP_TICK, ns_pin, mode_pin, 8'($urandom_range(255)));
   endtask

   task automatic send_line();
      foreach (line_buf[i])
         send_request(bdcl_pkg::OP_BYTE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      line_buf[i]);
      line_buf.delete();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back(s[i]);
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(3))
         0: return bdcl_pkg::CHAR_SPACE;
         1: return bdcl_pkg::CHAR_TAB;
         2: return bdcl_pkg::CHAR_VT;
         default: return bdcl_pkg::CHAR_FF;
      endcase
   endfunction

   function automatic logic [7:0] line_end();
      return $urandom_range(1) ? bdcl_pkg::CHAR_CR : bdcl_pkg::CHAR_LF;
   endfunction

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == bdcl_pkg::CHAR_CR || c == bdcl_pkg::CHAR_LF);
      return c;
   endfunction

   function automatic logic [7:0] random_case(logic [7:0] c);
      if (c >= "A" && c <= "Z" && $urandom_range(1))
         return c + bdcl_pkg::CASE_SHIFT;
      return c;
   endfunction

   task automatic push_word();
      string word;
      word = command_words[$urandom_range(bdcl_pkg::NUM_KW - 1)];
      case ($urandom_range(9))
         0: begin
            word = word.substr(0, $urandom_range(word.len() - 2));
         end
         1: begin
            word = {word, "S"};
         end
         2: begin
            repeat ($urandom_range(1, 10))
               line_buf.push_back(random_case(8'(8'h41 + $urandom_range(25))));
            return;
         end
         3: begin
            word[$urandom_range(word.len() - 1)] = "X";
         end
         default: begin
         end
      endcase
      for (int i = 0; i < word.len(); i++)
         line_buf.push_back(random_case(word[i]));
   endtask

   task automatic send_command_line();
      repeat ($urandom_range(2)) line_buf.push_back(blank_char());
      push_word();
      if ($urandom_range(1)) begin
         line_buf.push_back(blank_char());
         repeat ($urandom_range(5)) line_buf.push_back(text_char());
      end else if ($urandom_range(7) == 0) begin
         line_buf.push_back(bdcl_pkg::CHAR_NUL);
         repeat ($urandom_range(5)) line_buf.push_back(text_char());
      end
      line_buf.push_back(line_end());
      send_line();
   endtask

   task automatic send_long_line();
      if ($urandom_range(1)) begin
         repeat ($urandom_range(52, 70)) line_buf.push_back(blank_char());
         push_word();
      end else begin
         push_word();
         repeat ($urandom_range(56, 80)) line_buf.push_back(text_char());
      end
      line_buf.push_back(line_end());
      send_line();
   endtask

   task automatic send_odd_line();
      case ($urandom_range(3))
         0: begin
         end
         1: begin
            repeat ($urandom_range(1, 4)) line_buf.push_back(blank_char());
         end
         2: begin
            line_buf.push_back(bdcl_pkg::CHAR_NUL);
            push_word();
         end
         default: begin
            push_word();
            line_buf.push_back(bdcl_pkg::CHAR_NUL);
            repeat (3) line_buf.push_back(text_char());
         end
      endcase
      line_buf.push_back(line_end());
      send_line();
   endtask

   task automatic send_tick_burst();
      logic ns_pin;
      logic mode_pin;
      ns_pin   = 1'($urandom_range(1));
      mode_pin = 1'($urandom_range(1));
      repeat ($urandom_range(current_debounce + 3)) begin
         if ($urandom_range(9) == 0)
            send_tick(~ns_pin, mode_pin);
         else if ($urandom_range(9) == 0)
            send_tick(ns_pin, ~mode_pin);
         else
            send_tick(ns_pin, mode_pin);
      end
   endtask

   task automatic run_random(input int count);
      int first;
      int pick;
      first = sent_items;
      while (sent_items - first < count) begin
         pick = $urandom_range(99);
         if (pick < 30)
            send_command_line();
         else if (pick < 48)
            send_tick_burst();
         else if (pick < 60)
            send_take();
         else if (pick < 66)
            send_long_line();
         else if (pick < 74)
            send_odd_line();
         else
            send_request(2'($urandom_range(3)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 8'($urandom_range(255)));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (latch_board.outstanding() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [bdcl_pkg::TICKS_W-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      latch_board.set_debounce(value);
      current_debounce = int'(value);
   endtask

   initial begin
      latch_board              = new();
      reset                    = 1'b1;
      csr_write_enable         = 1'b0;
      csr_write_data           = '0;
      req_chan.valid           = 1'b0;
      req_chan.opcode          = bdcl_pkg::OP_TICK;
      req_chan.ns_button_low   = 1'b0;
      req_chan.mode_button_low = 1'b0;
      req_chan.rx_byte         = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      send_request(OP_UNUSED, 1'b1, 1'b1, 8'hFF);
      send_take();
      line_buf.push_back(bdcl_pkg::CHAR_CR);
      send_line();
      line_buf.push_back(bdcl_pkg::CHAR_SPACE);
      line_buf.push_back(bdcl_pkg::CHAR_TAB);
      push_text("nIgHt");
      line_buf.push_back(bdcl_pkg::CHAR_CR);
      send_line();
      send_take();
      line_buf.push_back(bdcl_pkg::CHAR_VT);
      line_buf.push_back(bdcl_pkg::CHAR_FF);
      line_buf.push_back(bdcl_pkg::CHAR_LF);
      send_line();
      line_buf.push_back(bdcl_pkg::CHAR_NUL);
      push_text("x");
      line_buf.push_back(bdcl_pkg::CHAR_LF);
      send_line();
      push_text("statusXY");
      line_buf.push_back(bdcl_pkg::CHAR_LF);
      send_line();

      foreach (phase_ticks[i]) begin
         drain();
         write_debounce(bdcl_pkg::TICKS_W'(phase_ticks[i]));
         steady_phase = (i == 2);
         run_random(135);
      end

      steady_phase = 1'b1;
      drain();
      write_debounce('1);
      repeat (20) send_tick(1'b1, 1'b1);
      send_take();
      drain();
      write_debounce('0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_take();
      steady_phase = 1'b0;

      drain();
      write_debounce(bdcl_pkg::TICKS_W'(5));
      run_random(135);

      drain();
      repeat (8) @(posedge clock);
      if (latch_board.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bdcl_pkg.sv
rtl/bdcl_if.sv
rtl/bdcl_debounce.sv
rtl/button_debounce_command_latch.sv
sim/latch_check_pkg.sv
sim/button_debounce_command_latch_tb.sv
